FILE: rtl/core/eal2d_pkg.sv
// Shared constants for the early-abandon squared L2 distance unit.
package eal2d_pkg;

    // Element pairs per abandon check.
    localparam int BLOCK_LEN = 8;
    localparam int POS_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    // Field widths.
    localparam int ELEM_W = 16;
    localparam int DIFF_W = ELEM_W + 1;
    localparam int MAG_W  = ELEM_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 48;

    // Stream data widths (fields packed from bit 0; both widths are whole bytes).
    localparam int S_DATA_W = 2 * ELEM_W + SUM_W;
    localparam int M_DATA_W = SUM_W;

    // Saturation ceiling of the accumulator.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Last position inside a block.
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);

endpackage

FILE: rtl/core/early_abandon_l2_distance_unit.sv
// Streaming squared L2 distance with early abandon at block boundaries.
//
//  Channel | Dir | Data bits (low to high)                    | Side band
//  --------+-----+--------------------------------------------+---------------------
//  s_      | in  | elem_a[15:0], elem_b[31:16], thresh[79:32] | tlast = last_element
//  m_      | out | distance[47:0]                             | tuser = abandoned
//
// One element pair is taken every cycle unless s_tready is low. A request passes
// the difference stage register and the square stage register, and then the
// accumulate stage loads the result register.
// The accumulate stage does a 48-bit saturating add and a compare.
// Reset clears all stage valid bits and the vector state.
// A stalled result register holds the accumulate stage; the earlier stages fill
// up behind it before s_tready drops.
module early_abandon_l2_distance_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [eal2d_pkg::S_DATA_W-1:0] s_tdata,   // elem_a, elem_b, threshold
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [eal2d_pkg::M_DATA_W-1:0] m_tdata,   // distance
    output logic                           m_tuser    // abandoned
);

    // Pipeline stage registers.
    logic                            p1_valid_reg;
    logic [eal2d_pkg::MAG_W-1:0]     p1_mag_reg;
    logic [eal2d_pkg::SUM_W-1:0]     p1_thr_reg;
    logic                            p1_last_reg;
    logic                            p2_valid_reg;
    logic [eal2d_pkg::SQ_W-1:0]      p2_sq_reg;
    logic [eal2d_pkg::SUM_W-1:0]     p2_thr_reg;
    logic                            p2_last_reg;

    // Vector state.
    logic [eal2d_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [eal2d_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [eal2d_pkg::SUM_W-1:0]     held_thr_reg, held_thr_next;
    logic                            skip_reg, skip_next;
    logic                            first_reg, first_next;

    // Result register.
    logic                            out_valid_reg, out_valid_next;
    logic [eal2d_pkg::SUM_W-1:0]     out_dist_reg, out_dist_next;
    logic                            out_aband_reg, out_aband_next;

    // Datapath signals.
    logic signed [eal2d_pkg::ELEM_W-1:0] elem_a, elem_b;
    logic signed [eal2d_pkg::DIFF_W-1:0] diff;
    logic [eal2d_pkg::DIFF_W-1:0]        diff_neg;
    logic [eal2d_pkg::MAG_W-1:0]         mag;
    logic [eal2d_pkg::SUM_W-1:0]         base_sum, eff_thr;
    logic [eal2d_pkg::POS_W-1:0]         base_pos;
    logic                                base_skip;
    logic [eal2d_pkg::SUM_W:0]           raw_sum;
    logic [eal2d_pkg::SUM_W-1:0]         sat_sum;
    logic                                block_done;

    // Handshake between stages.
    logic out_free, adv2, p2_open, adv1, in_acc;

    assign out_free = !out_valid_reg || m_tready;
    assign adv2     = p2_valid_reg && out_free;
    assign p2_open  = !p2_valid_reg || adv2;
    assign adv1     = p1_valid_reg && p2_open;
    assign s_tready = !p1_valid_reg || p2_open;
    assign in_acc   = s_tvalid && s_tready;

    // Difference magnitude; |a - b| fits 16 bits unsigned.
    assign elem_a   = s_tdata[eal2d_pkg::ELEM_W-1:0];
    assign elem_b   = s_tdata[2*eal2d_pkg::ELEM_W-1:eal2d_pkg::ELEM_W];
    assign diff     = eal2d_pkg::DIFF_W'(elem_a) - eal2d_pkg::DIFF_W'(elem_b);
    assign diff_neg = -diff;
    assign mag      = diff[eal2d_pkg::DIFF_W-1] ? diff_neg[eal2d_pkg::MAG_W-1:0]
                                                : diff[eal2d_pkg::MAG_W-1:0];

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                p1_valid_reg <= s_tvalid;
            end
            if (p2_open) begin
                p2_valid_reg <= p1_valid_reg;
            end
        end
    end

    // Stage payloads: difference, then square.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            p1_mag_reg  <= mag;
            p1_thr_reg  <= s_tdata[eal2d_pkg::S_DATA_W-1:2*eal2d_pkg::ELEM_W];
            p1_last_reg <= s_tlast;
        end
        if (adv1) begin
            p2_sq_reg   <= p1_mag_reg * p1_mag_reg;
            p2_thr_reg  <= p1_thr_reg;
            p2_last_reg <= p1_last_reg;
        end
    end

    // Accumulate, check the block boundary and decide on a result.
    always_comb begin
        base_sum   = first_reg ? '0 : sum_reg;
        base_pos   = first_reg ? '0 : pos_reg;
        base_skip  = first_reg ? 1'b0 : skip_reg;
        eff_thr    = first_reg ? p2_thr_reg : held_thr_reg;
        raw_sum    = {1'b0, base_sum} + (eal2d_pkg::SUM_W + 1)'(p2_sq_reg);
        sat_sum    = raw_sum[eal2d_pkg::SUM_W] ? eal2d_pkg::SUM_MAX
                                               : raw_sum[eal2d_pkg::SUM_W-1:0];
        block_done = (base_pos == eal2d_pkg::POS_LAST);

        sum_next       = sum_reg;
        pos_next       = pos_reg;
        held_thr_next  = held_thr_reg;
        skip_next      = skip_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_dist_next  = out_dist_reg;
        out_aband_next = out_aband_reg;

        if (adv2) begin
            held_thr_next = eff_thr;
            first_next    = p2_last_reg;
            if (base_skip) begin
                // Rest of an abandoned vector: drop it, end on its last element.
                skip_next = !p2_last_reg;
            end else begin
                sum_next  = sat_sum;
                pos_next  = block_done ? '0 : base_pos + 1'b1;
                skip_next = 1'b0;
                if (p2_last_reg) begin
                    out_valid_next = 1'b1;
                    out_dist_next  = sat_sum;
                    out_aband_next = 1'b0;
                end else if (block_done && (sat_sum > eff_thr)) begin
                    out_valid_next = 1'b1;
                    out_dist_next  = sat_sum;
                    out_aband_next = 1'b1;
                    skip_next      = 1'b1;
                end
            end
        end
    end

    // Vector state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            pos_reg       <= '0;
            held_thr_reg  <= '0;
            skip_reg      <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            held_thr_reg  <= held_thr_next;
            skip_reg      <= skip_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_dist_reg  <= out_dist_next;
        out_aband_reg <= out_aband_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_aband_reg;

endmodule

FILE: rtl/core/eal2d_checker.sv
// Port-level checks for the early-abandon squared L2 distance unit.
module eal2d_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [eal2d_pkg::S_DATA_W-1:0] s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [eal2d_pkg::M_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A waiting request keeps its contents until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("request changed while waiting");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An abandoned request always carries a sum above some threshold, so not zero.
    a_abandon_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata != '0)
        else $error("abandoned result with zero distance");

    // With the result register empty the whole pipeline moves, so input is taken.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind early_abandon_l2_distance_unit eal2d_checker u_eal2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
